// ----- hw/rtl/wtwq_pkg.sv -----
`timescale 1ns / 1ps

package wtwq_pkg;

  localparam int QueueDepth = 16;
  localparam int TaskBits   = 8;
  localparam int TimeW      = 32;

  // Request codes
  localparam logic [1:0] REQ_ENQ_ORDERED = 2'd0;
  localparam logic [1:0] REQ_ENQ_TAIL    = 2'd1;
  localparam logic [1:0] REQ_DEQ         = 2'd2;
  localparam logic [1:0] REQ_FLUSH       = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ENQ   = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_DEQ   = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  // Per-cell move command.
  typedef struct packed {
    logic load_new;
    logic from_prev;
    logic from_next;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/wtwq_cell.sv -----
`timescale 1ns / 1ps

module wtwq_cell #(
  parameter int TASK_BITS = wtwq_pkg::TaskBits
) (
  input  logic                         clk,
  input  wtwq_pkg::cell_ctl_t          ctl,
  input  logic [TASK_BITS-1:0]         new_task,
  input  logic [wtwq_pkg::TimeW-1:0]   new_time,
  input  logic [TASK_BITS-1:0]         prev_task,
  input  logic [wtwq_pkg::TimeW-1:0]   prev_time,
  input  logic [TASK_BITS-1:0]         next_task,
  input  logic [wtwq_pkg::TimeW-1:0]   next_time,
  input  logic [wtwq_pkg::TimeW-1:0]   key,
  output logic [TASK_BITS-1:0]         task_q,
  output logic [wtwq_pkg::TimeW-1:0]   time_q,
  output logic                         gt
);

  logic [TASK_BITS-1:0]       task_r;
  logic [wtwq_pkg::TimeW-1:0] time_r;

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      task_r <= new_task;
      time_r <= new_time;
    end else if (ctl.from_prev) begin
      task_r <= prev_task;
      time_r <= prev_time;
    end else if (ctl.from_next) begin
      task_r <= next_task;
      time_r <= next_time;
    end
  end

  assign task_q = task_r;
  assign time_q = time_r;
  // Strictly greater, so equal wake times keep arrival order.
  assign gt     = time_r > key;

endmodule

// ----- hw/rtl/wake_time_ordered_wait_queue_top.sv -----
`timescale 1ns / 1ps

// Channel   Ports                                          Handshake
// input     in_req_type, in_task_id, in_wake_time          start && !busy
// result    out_status, out_task, out_time, out_occupancy,  out_valid, one cycle
//           out_last
//
// A new request is accepted every cycle while busy is low; enqueue and dequeue never raise busy.
// A flush of N entries keeps busy high after acceptance until its last entry is popped and
// emits one result per cycle, one cell shift per pop.
// Each result is registered and appears in the cycle after the request or pop that causes it.
// Reset empties the queue; entry contents are not cleared.
// The receiver cannot stall; results are never held.
module wake_time_ordered_wait_queue_top #(
  parameter int QUEUE_DEPTH = wtwq_pkg::QueueDepth,
  parameter int TASK_BITS   = wtwq_pkg::TaskBits
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_wake_time,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [7:0]  out_task,
  output logic [31:0] out_time,
  output logic [4:0]  out_occupancy,
  output logic        out_last
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = wtwq_pkg::TimeW;

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FLUSH = 1'b1;

  logic                 state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [7:0]           out_task_r, out_task_nxt;
  logic [TW-1:0]        out_time_r, out_time_nxt;
  logic [CW-1:0]        out_occ_r, out_occ_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [TASK_BITS-1:0] cell_task [QUEUE_DEPTH];
  logic [TW-1:0]        cell_time [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gt, hit, lowest, after;
  wtwq_pkg::cell_ctl_t  ctl [QUEUE_DEPTH];

  logic                 accept, is_enq, full, empty, do_ins, do_pop;
  logic [TASK_BITS+7:0] task_in_wide;
  logic [TASK_BITS-1:0] new_task;
  logic [TW-1:0]        new_time;
  logic [TASK_BITS+7:0] head_task_wide;
  logic [CW+4:0]        occ_wide;

  assign accept = start && (state_r == S_IDLE);
  assign is_enq = (in_req_type == wtwq_pkg::REQ_ENQ_ORDERED) ||
                  (in_req_type == wtwq_pkg::REQ_ENQ_TAIL);
  assign full   = count_r == CW'(QUEUE_DEPTH);
  assign empty  = count_r == '0;
  assign do_ins = accept && is_enq && !full;
  assign do_pop = (state_r == S_FLUSH) ||
                  (accept && !is_enq && !empty);

  assign task_in_wide = {{TASK_BITS{1'b0}}, in_task_id};
  assign new_task     = task_in_wide[TASK_BITS-1:0];
  assign new_time     = (in_req_type == wtwq_pkg::REQ_ENQ_ORDERED) ? in_wake_time : '0;

  // Insertion point: the first cell past the tail, or for an ordered enqueue
  // the first held cell whose time is strictly greater than the key.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = (CW'(i) >= count_r) ||
               ((in_req_type == wtwq_pkg::REQ_ENQ_ORDERED) && gt[i]);
    end
  end

  assign lowest = hit & (~hit + 1'b1);
  assign after  = ~(lowest | (lowest - 1'b1));

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [TASK_BITS-1:0] prev_task, next_task;
      logic [TW-1:0]        prev_time, next_time;

      assign ctl[g].load_new  = do_ins && lowest[g];
      assign ctl[g].from_prev = do_ins && after[g];
      assign ctl[g].from_next = do_pop;

      if (g == 0) begin : g_first
        assign prev_task = new_task;
        assign prev_time = new_time;
      end else begin : g_mid
        assign prev_task = cell_task[g-1];
        assign prev_time = cell_time[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
        assign next_task = cell_task[g];
        assign next_time = cell_time[g];
      end else begin : g_inner
        assign next_task = cell_task[g+1];
        assign next_time = cell_time[g+1];
      end

      wtwq_cell #(
        .TASK_BITS (TASK_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl[g]),
        .new_task  (new_task),
        .new_time  (new_time),
        .prev_task (prev_task),
        .prev_time (prev_time),
        .next_task (next_task),
        .next_time (next_time),
        .key       (in_wake_time),
        .task_q    (cell_task[g]),
        .time_q    (cell_time[g]),
        .gt        (gt[g])
      );
    end
  endgenerate

  assign head_task_wide = {8'd0, cell_task[0]};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = wtwq_pkg::ST_EMPTY;
    out_task_nxt   = '0;
    out_time_nxt   = '0;
    out_occ_nxt    = count_r;
    out_last_nxt   = 1'b1;
    if (state_r == S_FLUSH) begin
      count_nxt      = count_r - 1'b1;
      out_valid_nxt  = 1'b1;
      out_status_nxt = wtwq_pkg::ST_FLUSH;
      out_task_nxt   = head_task_wide[7:0];
      out_time_nxt   = cell_time[0];
      out_occ_nxt    = count_r - 1'b1;
      out_last_nxt   = count_r == CW'(1);
      if (count_r == CW'(1)) begin
        state_nxt = S_IDLE;
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
      case (in_req_type)
        wtwq_pkg::REQ_ENQ_ORDERED, wtwq_pkg::REQ_ENQ_TAIL: begin
          if (full) begin
            out_status_nxt = wtwq_pkg::ST_FULL;
          end else begin
            count_nxt      = count_r + 1'b1;
            out_status_nxt = wtwq_pkg::ST_ENQ;
            out_occ_nxt    = count_r + 1'b1;
          end
        end
        wtwq_pkg::REQ_DEQ, wtwq_pkg::REQ_FLUSH: begin
          if (!empty) begin
            count_nxt      = count_r - 1'b1;
            out_status_nxt = (in_req_type == wtwq_pkg::REQ_DEQ) ?
                             wtwq_pkg::ST_DEQ : wtwq_pkg::ST_FLUSH;
            out_task_nxt   = head_task_wide[7:0];
            out_time_nxt   = cell_time[0];
            out_occ_nxt    = count_r - 1'b1;
            if (in_req_type == wtwq_pkg::REQ_FLUSH && count_r != CW'(1)) begin
              out_last_nxt = 1'b0;
              state_nxt    = S_FLUSH;
            end
          end
        end
        default: begin
          out_status_nxt = wtwq_pkg::ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_task_r   <= out_task_nxt;
    out_time_r   <= out_time_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign occ_wide      = {5'd0, out_occ_r};
  assign busy          = state_r == S_FLUSH;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_task      = out_task_r;
  assign out_time      = out_time_r;
  assign out_occupancy = occ_wide[4:0];
  assign out_last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) |-> (count_r != '0))
    else $error("flush running on an empty queue");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  a_notlast_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (state_r == S_FLUSH))
    else $error("non-final result outside a flush");

  a_single_move: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_ins && do_pop))
    else $error("insert and pop in the same cycle");

endmodule
